// File: hw/rtl/fjc_pkg.sv
package fjc_pkg;

  localparam int FORCE_W   = 16;               // one force component, signed Q8.8
  localparam int MAG_W     = 16;               // magnitude, unsigned Q8.8
  localparam int SUM_W     = 2 * MAG_W;        // sum of squares, Q16.16
  localparam int SQ_W      = 2 * FORCE_W - 1;  // one square, at most 2^30
  localparam int CHG_W     = MAG_W + 1;        // signed magnitude change
  localparam int THR_W     = 16;
  localparam int AXES      = 3;

  localparam logic [THR_W-1:0] THR_RESET = 16'd1280;  // 5.0 N in Q8.8
  localparam int HISTORY_DEPTH_DEF = 3;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

endpackage

// File: hw/rtl/fjc_sumsq.sv
module fjc_sumsq
  import fjc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [AXES*FORCE_W-1:0]       forces,   // x, y, z from the lowest bits
  output logic                          done,
  output logic [SUM_W-1:0]              sum
);

  logic [AXES*FORCE_W-1:0] ops_r;
  logic [SQ_W-1:0]         prod_r;
  logic [SUM_W-1:0]        acc_r;
  logic [1:0]              cnt_r;
  logic                    busy_r;
  logic                    done_r;
  logic signed [2*FORCE_W-1:0] sq;

  // one square per cycle, registered before the accumulate
  assign sq = $signed(ops_r[FORCE_W-1:0]) * $signed(ops_r[FORCE_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'(AXES)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ops_r <= forces;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != 2'(AXES)) begin
        prod_r <= sq[SQ_W-1:0];
        ops_r  <= ops_r >> FORCE_W;
      end
      if (cnt_r != 2'd0) begin
        acc_r <= acc_r + SUM_W'(prod_r);
      end
    end
  end

  assign done = done_r;
  assign sum  = acc_r;

endmodule

// File: hw/rtl/fjc_sqrt.sv
module fjc_sqrt
  import fjc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] radicand,
  output logic             done,
  output logic [MAG_W-1:0] root
);

  localparam int CNT_W = $clog2(MAG_W);

  logic [SUM_W-1:0] rad_r;
  logic [MAG_W:0]   rem_r;
  logic [MAG_W-1:0] root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [MAG_W+2:0] rem_ext;
  logic [MAG_W+2:0] trial;
  logic [MAG_W+2:0] rem_sub;
  logic             fits;

  // restoring recurrence: two radicand bits in, one root bit out per cycle
  assign rem_ext = {rem_r, rad_r[SUM_W-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign fits    = (rem_ext >= trial);
  // remainder stays below 2*root + 1, so MAG_W+1 bits hold it
  assign rem_sub = rem_ext - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= rad_r << 2;
      if (fits) begin
        rem_r  <= rem_sub[MAG_W:0];
        root_r <= {root_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_ext[MAG_W:0];
        root_r <= {root_r[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: hw/rtl/force_jump_collision_latch.sv
// Force jump collision latch. Each input word is either a force sample
// (x, y, z signed Q8.8 N) or a latch-clear command, selected by in_tuser.
// A sample's magnitude is floor(sqrt(x^2 + y^2 + z^2)) in Q8.8; the last
// HISTORY_DEPTH magnitudes are kept. The first HISTORY_DEPTH samples only
// fill the history; after that each sample shifts it and the change
// oldest - newest is taken, and |change| > jump_threshold sets the sticky
// collision flag. While the flag is set samples are dropped and the
// history is frozen; a clear word drops the flag and nothing else. Every
// input word gives exactly one output word (flag, last change).
// Words are handled one at a time. A sample passes from accept to output
// through the squares on one shared 16x16 multiplier, a root load, the
// bit-serial root, an update step and an output load; a new word is taken
// only after the last one has been loaded to the output register. Clear
// words and dropped samples go straight to the output load.
// A pending output word does not block the next accept; the result of the
// next word waits until the output register is free.
module force_jump_collision_latch
  import fjc_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF  // 2 .. 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // config: jump_threshold, Q8.8 N
  input  logic                  cfg_wr_en,
  input  logic [THR_W-1:0]      cfg_wr_data,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // force_x[15:0], force_y[31:16], force_z[47:32]
  input  logic                  in_tuser,   // cmd: 0 sample, 1 clear latch
  // output stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // collision[0], magnitude_change[17:1], zero pad
);

  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAG,
    S_RESULT
  } state_t;

  state_t                  state_r;
  logic [THR_W-1:0]        thr_r;
  logic [MAG_W-1:0]        hist_r [HISTORY_DEPTH];
  logic [FILL_W-1:0]       fill_r;
  logic                    collision_r;
  logic signed [CHG_W-1:0] last_change_r;
  logic                    out_tvalid_r;
  logic [OUT_DATA_W-1:0]   out_tdata_r;

  logic                    in_acc;
  logic                    is_sample;
  logic                    sumsq_done;
  logic [SUM_W-1:0]        sum;
  logic                    sqrt_done;
  logic [MAG_W-1:0]        mag;
  logic signed [CHG_W-1:0] diff;
  logic [CHG_W-1:0]        diff_abs;
  logic                    out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  // a sample only goes through the magnitude path while unlatched
  assign is_sample = (in_tuser == CMD_SAMPLE) && !collision_r;
  assign out_free  = !out_tvalid_r || out_tready;

  fjc_sumsq u_sumsq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc && is_sample),
    .forces (in_tdata[AXES*FORCE_W-1:0]),
    .done   (sumsq_done),
    .sum    (sum)
  );

  fjc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sumsq_done),
    .radicand (sum),
    .done     (sqrt_done),
    .root     (mag)
  );

  // after the shift, hist_r[1] becomes the oldest entry
  assign diff     = $signed({1'b0, hist_r[1]}) - $signed({1'b0, mag});
  assign diff_abs = diff[CHG_W-1] ? CHG_W'(-diff) : CHG_W'(diff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      fill_r        <= '0;
      collision_r   <= 1'b0;
      last_change_r <= '0;
      out_tvalid_r  <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      // S_RESULT owns the valid bit while it waits to load
      if (out_tready && state_r != S_RESULT) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tuser == CMD_CLEAR) begin
              collision_r <= 1'b0;
              state_r     <= S_RESULT;
            end else if (collision_r) begin
              state_r <= S_RESULT;
            end else begin
              state_r <= S_MAG;
            end
          end
        end
        S_MAG: begin
          if (sqrt_done) begin
            if (fill_r < FILL_W'(HISTORY_DEPTH)) begin
              for (int i = 0; i < HISTORY_DEPTH; i++) begin
                if (fill_r == FILL_W'(i)) begin
                  hist_r[i] <= mag;
                end
              end
              fill_r <= fill_r + FILL_W'(1);
            end else begin
              for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                hist_r[i] <= hist_r[i+1];
              end
              hist_r[HISTORY_DEPTH-1] <= mag;
              last_change_r <= diff;
              if (diff_abs > CHG_W'(thr_r)) begin
                collision_r <= 1'b1;
              end
            end
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= OUT_DATA_W'({last_change_r, collision_r});
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // fill count and last change hold while the flag is set
  a_frozen_while_latched: assert property (@(posedge clk) disable iff (!rst_n)
    collision_r |=> $stable(fill_r) && $stable(last_change_r))
    else $error("history moved while latched");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HISTORY_DEPTH))
    else $error("fill count beyond history depth");

  a_root_in_mag: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> state_r == S_MAG)
    else $error("root finished outside magnitude phase");

  a_latch_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(collision_r) |-> $past(state_r) == S_MAG && $past(sqrt_done))
    else $error("latch set without a magnitude update");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

// Block-level test of force_jump_collision_latch.
// Words go in on the in_ stream (force sample or latch clear) and every word
// gives one word back on the out_ stream. A behavioral copy of the block runs
// beside it: each accepted input word updates that copy and queues the flag
// and change it should report. The checker pops one entry per output word and
// compares the two fields. Both stream sides idle at random, and the jump
// threshold is rewritten between phases while the block is idle.
module testbench;
  import fjc_pkg::*;

  localparam int HIST_DEPTH     = HISTORY_DEPTH_DEF;
  localparam int DRAIN_CYCLES   = 40;    // extra wait at the end, after all outputs are back
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving on either side
  localparam int MAX_REPORTS    = 30;

  typedef struct packed {
    logic                    collision;
    logic signed [CHG_W-1:0] change;
  } latch_result_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [THR_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;  // force_x[15:0], force_y[31:16], force_z[47:32]
  logic                  in_tuser    = 1'b0;  // cmd: sample or clear latch
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // collision[0], magnitude_change[17:1], zero pad

  // behavioral copy of the block state
  logic [MAG_W-1:0]        mirror_hist [HIST_DEPTH];
  int                      mirror_fill;
  logic                    mirror_latch;
  logic signed [CHG_W-1:0] mirror_change;
  logic [THR_W-1:0]        mirror_thr;

  latch_result_t pending_results[$];
  int            mismatches    = 0;
  int            idle_cycles   = 0;
  int            rx_stall_left = 0;
  bit            stalls_on     = 1'b1;

  // random walk position for the sample stream
  logic [FORCE_W-1:0] walk_x = '0;
  logic [FORCE_W-1:0] walk_y = '0;
  logic [FORCE_W-1:0] walk_z = '0;

  force_jump_collision_latch dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!stalls_on || r < 60) return 0;
    if (r < 94) return $urandom_range(1, 5);
    return $urandom_range(15, 60);
  endfunction

  // floor sqrt of x^2 + y^2 + z^2, one result bit per pass, top bit first
  function automatic logic [MAG_W-1:0] force_magnitude(input logic [FORCE_W-1:0] fx,
                                                       input logic [FORCE_W-1:0] fy,
                                                       input logic [FORCE_W-1:0] fz);
    logic signed [33:0] ax, ay, az;
    logic [33:0]        energy;
    logic [33:0]        trial_sq;
    logic [MAG_W-1:0]   root;
    logic [MAG_W-1:0]   trial;
    int                 b;
    ax = $signed(fx);
    ay = $signed(fy);
    az = $signed(fz);
    energy = ax * ax + ay * ay + az * az;
    root = '0;
    for (b = MAG_W - 1; b >= 0; b--) begin
      trial = root | (MAG_W'(1) << b);
      trial_sq = {18'd0, trial} * {18'd0, trial};
      if (trial_sq <= energy) root = trial;
    end
    return root;
  endfunction

  // advances the mirror by one input word, returns what the block must report
  function automatic latch_result_t predict_latch_word(input logic cmd,
                                                       input logic [FORCE_W-1:0] fx,
                                                       input logic [FORCE_W-1:0] fy,
                                                       input logic [FORCE_W-1:0] fz);
    latch_result_t    res;
    logic [MAG_W-1:0] mag;
    logic [CHG_W-1:0] jump_abs;
    int               i;
    if (cmd == CMD_CLEAR) begin
      mirror_latch = 1'b0;
    end else if (!mirror_latch) begin
      mag = force_magnitude(fx, fy, fz);
      if (mirror_fill < HIST_DEPTH) begin
        // still filling: append only, flag and change keep their values
        mirror_hist[mirror_fill] = mag;
        mirror_fill++;
      end else begin
        for (i = 0; i < HIST_DEPTH - 1; i++) mirror_hist[i] = mirror_hist[i + 1];
        mirror_hist[HIST_DEPTH - 1] = mag;
        mirror_change = $signed({1'b0, mirror_hist[0]})
                      - $signed({1'b0, mirror_hist[HIST_DEPTH - 1]});
        jump_abs = mirror_change[CHG_W-1] ? -mirror_change : mirror_change;
        if (jump_abs > {1'b0, mirror_thr}) mirror_latch = 1'b1;
      end
    end
    res.collision = mirror_latch;
    res.change    = mirror_change;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  // one input word; valid stays up on return so a following word can go back to back
  task automatic send_word(input logic cmd,
                           input logic [FORCE_W-1:0] fx,
                           input logic [FORCE_W-1:0] fy,
                           input logic [FORCE_W-1:0] fz);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {fz, fy, fx};
    do @(posedge clk); while (!in_tready);
    pending_results.insert(pending_results.size(), predict_latch_word(cmd, fx, fy, fz));
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // only written with nothing in flight
  task automatic set_jump_threshold(input logic [THR_W-1:0] value);
    idle_input();
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mirror_thr = value;
  endtask

  // random walk of the force vector with full-range jumps and clears mixed in
  task automatic run_force_walk(input int count);
    int               i, r;
    logic [31:0]      span;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 2))
        0: span = 3;
        1: span = 48;
        default: span = 700;
      endcase
      if ((mirror_latch && r < 55) || r < 5) begin
        // clear, forces are junk
        send_word(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (r < 14) begin
        walk_x = 16'($urandom);
        walk_y = 16'($urandom);
        walk_z = 16'($urandom);
        send_word(CMD_SAMPLE, walk_x, walk_y, walk_z);
      end else begin
        walk_x = walk_x + 16'($urandom_range(0, 2 * span) - span);
        walk_y = walk_y + 16'($urandom_range(0, 2 * span) - span);
        walk_z = walk_z + 16'($urandom_range(0, 2 * span) - span);
        send_word(CMD_SAMPLE, walk_x, walk_y, walk_z);
      end
    end
  endtask

  // runs at the reset threshold (5.0 N), no register write before it
  task automatic test_fill_and_boundaries();
    // filling phase: zero, near-max positive, full negative
    send_word(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_word(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
    // history full: tiny change, then the largest positive jump
    send_word(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
    send_word(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
    // latched: this sample must leave history and change alone
    send_word(CMD_SAMPLE, 16'h0001, 16'hFFFF, 16'h1234);
    send_word(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // largest negative jump
    send_word(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
    send_word(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
    // clear twice, the second with nothing latched
    send_word(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_CLEAR, 16'h5555, 16'hAAAA, 16'h5555);
    // bring the history to 1000 on each axis in turn
    send_word(CMD_SAMPLE, 16'd1000, 16'h0000, 16'h0000);
    send_word(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_SAMPLE, 16'h0000, 16'(-1000), 16'h0000);
    send_word(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_SAMPLE, 16'h0000, 16'h0000, 16'd1000);
    // change equal to the threshold holds, one above latches
    send_word(CMD_SAMPLE, 16'd2280, 16'h0000, 16'h0000);
    send_word(CMD_SAMPLE, 16'h0000, 16'(-2281), 16'h0000);
    send_word(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    // positive side: change equal to the threshold holds, a larger one latches
    send_word(CMD_SAMPLE, 16'h0000, 16'h0000, 16'(-1000));
    send_word(CMD_SAMPLE, 16'd999, 16'h0000, 16'h0000);
    send_word(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    // a perfect-square sum and a non-square sum on all three axes
    send_word(CMD_SAMPLE, 16'd3, 16'd4, 16'd12);
    send_word(CMD_SAMPLE, 16'd1, 16'hFFFF, 16'd1);
  endtask

  // threshold 0: any nonzero change latches
  task automatic test_threshold_zero();
    set_jump_threshold('0);
    run_force_walk(150);
  endtask

  // threshold all ones: the largest change can never latch
  task automatic test_threshold_full();
    set_jump_threshold('1);
    send_word(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
    send_word(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
    run_force_walk(150);
  endtask

  // assorted thresholds; one phase runs with no idling on either side
  task automatic test_random_thresholds();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_jump_threshold(THR_RESET);
        1: set_jump_threshold(THR_W'($urandom_range(0, 3000)));
        2: set_jump_threshold(THR_W'($urandom_range(1, 200)));
        3: set_jump_threshold(THR_W'($urandom));
        4: set_jump_threshold(THR_W'($urandom_range(500, 8000)));
        default: set_jump_threshold(THR_RESET);
      endcase
      stalls_on = (phase != 2);
      run_force_walk(250);
    end
    stalls_on = 1'b1;
  endtask

  // receiver: ready most of the time, random stalls of mixed length
  always @(posedge clk) begin
    if (rx_stall_left > 0) begin
      out_tready    <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (stalls_on && $urandom_range(0, 9) == 0) rx_stall_left <= pick_gap();
    end
  end

  // result check, one output word per edge at most
  always @(posedge clk) begin
    latch_result_t want;
    logic          got_collision;
    logic [CHG_W-1:0] got_change;
    if (rst_n && out_tvalid && out_tready) begin
      got_collision = out_tdata[0];
      got_change    = out_tdata[CHG_W:1];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected output word %h", out_tdata));
      end else begin
        want = pending_results.pop_front();
        if (got_collision !== want.collision)
          report_mismatch($sformatf("collision %b, expected %b",
                                    got_collision, want.collision));
        if (got_change !== want.change)
          report_mismatch($sformatf("magnitude_change %0d, expected %0d",
                                    $signed(got_change), want.change));
      end
    end
  end

  // watchdog: nothing moving on either stream for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    for (i = 0; i < HIST_DEPTH; i++) mirror_hist[i] = '0;
    mirror_fill   = 0;
    mirror_latch  = 1'b0;
    mirror_change = '0;
    mirror_thr    = THR_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_and_boundaries();
    test_threshold_zero();
    test_threshold_full();
    test_random_thresholds();

    idle_input();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
